// File: hdl/assert_macros.svh
// assertion macros shared by the sequencer rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// implication checked on the same edge, disabled in reset
`define I2CBC_ASSERT_SAME(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// implication with the consequent checked in the next cycle, disabled in reset
`define I2CBC_ASSERT_NEXT(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: hdl/i2cbc_pkg.sv
// types and constants for the i2c bus clear sequencer
`timescale 1ns / 1ps

package i2cbc_pkg;

    localparam int CFG_INDEX_W   = 4;
    localparam int CFG_DATA_W    = 24;
    localparam int CFG_TIMEOUT_W = 24;
    localparam int PULSE_W       = 5;

    // configuration register indexes
    localparam logic [CFG_INDEX_W-1:0] CFG_PINS_CONFIGURED     = 4'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_SCL_RELEASE_TIMEOUT = 4'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_STRETCH_TIMEOUT     = 4'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_MAX_PULSES          = 4'd3;

    // configuration reset values
    localparam logic [CFG_TIMEOUT_W-1:0] RST_SCL_RELEASE_TIMEOUT = 24'd250000;
    localparam logic [CFG_TIMEOUT_W-1:0] RST_STRETCH_TIMEOUT     = 24'd200000;
    localparam logic [PULSE_W-1:0]       RST_MAX_PULSES          = 5'd20;

    typedef enum logic [2:0] {
        PH_IDLE          = 3'd0,
        PH_WAIT_SCL      = 3'd1,
        PH_SDA_CHECK     = 3'd2,
        PH_PULSE_RELEASE = 3'd3,
        PH_PULSE_CHECK   = 3'd4,
        PH_STRETCH       = 3'd5,
        PH_STOP_COND     = 3'd6,
        PH_FINISH        = 3'd7
    } phase_t;

    typedef enum logic [2:0] {
        ST_IDLE      = 3'd0,
        ST_NOT_CONF  = 3'd1,
        ST_OK        = 3'd2,
        ST_CLEARING  = 3'd3,
        ST_SCL_STUCK = 3'd4,
        ST_SDA_STUCK = 3'd5,
        ST_STRETCH   = 3'd6,
        ST_CLEARED   = 3'd7
    } status_t;

    typedef struct packed {
        logic scl_level;
        logic sda_level;
        logic check_request;
    } tick_t;

    typedef struct packed {
        status_t status;
        logic    scl_drive_low;
        logic    sda_drive_low;
        logic    pullup_enable;
    } result_t;

    typedef struct packed {
        logic                     pins_configured;
        logic [CFG_TIMEOUT_W-1:0] scl_release_timeout;
        logic [CFG_TIMEOUT_W-1:0] stretch_timeout;
        logic [PULSE_W-1:0]       max_pulses;
    } cfg_t;

endpackage

// File: hdl/i2cbc_stream_if.sv
// valid/ready stream channel carrying one word per handshake
`timescale 1ns / 1ps

interface i2cbc_stream_if #(
    parameter type payload_t = logic
) ();
    logic     valid;
    logic     ready;
    payload_t payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

// File: hdl/i2cbc_cfg_if.sv
// configuration write channel
`timescale 1ns / 1ps

interface i2cbc_cfg_if ();
    import i2cbc_pkg::*;

    logic                   valid;
    logic                   ready;
    logic [CFG_INDEX_W-1:0] index;
    logic [CFG_DATA_W-1:0]  data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// File: hdl/i2cbc_cfg_regs.sv
// configuration register file
`timescale 1ns / 1ps

module i2cbc_cfg_regs (
    input  logic            clk,
    input  logic            rst_n,
    i2cbc_cfg_if.sink       cfg,
    output i2cbc_pkg::cfg_t cfg_word
);
    import i2cbc_pkg::*;

    cfg_t cfg_reg;
    cfg_t cfg_next;

    assign cfg.ready = 1'b1;
    assign cfg_word  = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg.valid)
        begin
            unique case (cfg.index)
                CFG_PINS_CONFIGURED:     cfg_next.pins_configured = cfg.data[0];
                CFG_SCL_RELEASE_TIMEOUT: cfg_next.scl_release_timeout =
                                             cfg.data[CFG_TIMEOUT_W-1:0];
                CFG_STRETCH_TIMEOUT:     cfg_next.stretch_timeout =
                                             cfg.data[CFG_TIMEOUT_W-1:0];
                CFG_MAX_PULSES:          cfg_next.max_pulses = cfg.data[PULSE_W-1:0];
                default:                 cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.pins_configured     <= 1'b0;
            cfg_reg.scl_release_timeout <= RST_SCL_RELEASE_TIMEOUT;
            cfg_reg.stretch_timeout     <= RST_STRETCH_TIMEOUT;
            cfg_reg.max_pulses          <= RST_MAX_PULSES;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

// File: hdl/i2cbc_seq_core.sv
// recovery state machine, wait timer and pulse budget
`timescale 1ns / 1ps

module i2cbc_seq_core #(
    parameter int TIMER_BITS = 24
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               accept,
    input  i2cbc_pkg::tick_t   tick_word,
    input  i2cbc_pkg::cfg_t    cfg_word,
    output i2cbc_pkg::result_t result_word
);
    import i2cbc_pkg::*;

    localparam int CMP_W = (TIMER_BITS > CFG_TIMEOUT_W) ? TIMER_BITS : CFG_TIMEOUT_W;
    localparam logic [TIMER_BITS-1:0] TIMER_MAX = {TIMER_BITS{1'b1}};

    phase_t                  phase_reg;
    phase_t                  phase_next;
    logic [TIMER_BITS-1:0]   wait_timer_reg;
    logic [TIMER_BITS-1:0]   wait_timer_next;
    logic [PULSE_W-1:0]      pulses_left_reg;
    logic [PULSE_W-1:0]      pulses_left_next;

    logic [TIMER_BITS-1:0]    timer_inc;
    logic [CFG_TIMEOUT_W-1:0] cur_timeout;
    logic                     expired;
    logic                     start_clear;
    logic                     decide;
    logic                     have_pulse;

    // saturating bump, then compare against the timeout for this wait
    assign timer_inc   = (wait_timer_reg == TIMER_MAX) ? wait_timer_reg
                                                       : wait_timer_reg + 1'b1;
    assign cur_timeout = (phase_reg == PH_STRETCH) ? cfg_word.stretch_timeout
                                                   : cfg_word.scl_release_timeout;
    assign expired     = CMP_W'(timer_inc) > CMP_W'(cur_timeout);
    assign start_clear = tick_word.check_request && cfg_word.pins_configured &&
                         !(tick_word.scl_level && tick_word.sda_level);
    // sda decision taken after scl seen high
    assign decide      = (phase_reg == PH_SDA_CHECK) ||
                         ((phase_reg == PH_PULSE_CHECK) && tick_word.scl_level);
    assign have_pulse  = (pulses_left_reg != '0);

    always_comb
    begin
        phase_next = phase_reg;
        unique case (phase_reg)
            PH_IDLE:
                if (start_clear)
                    phase_next = PH_WAIT_SCL;
            PH_WAIT_SCL, PH_STRETCH:
                if (tick_word.scl_level)
                    phase_next = PH_SDA_CHECK;
                else if (expired)
                    phase_next = PH_IDLE;
            PH_SDA_CHECK, PH_PULSE_CHECK:
                if (phase_reg == PH_PULSE_CHECK && !tick_word.scl_level)
                    phase_next = PH_STRETCH;
                else if (tick_word.sda_level)
                    phase_next = PH_STOP_COND;
                else if (have_pulse)
                    phase_next = PH_PULSE_RELEASE;
                else
                    phase_next = PH_IDLE;
            PH_PULSE_RELEASE:
                phase_next = PH_PULSE_CHECK;
            PH_STOP_COND:
                phase_next = PH_FINISH;
            PH_FINISH:
                phase_next = PH_IDLE;
        endcase
    end

    always_comb
    begin
        result_word = '{status: ST_IDLE, scl_drive_low: 1'b0,
                        sda_drive_low: 1'b0, pullup_enable: 1'b0};
        unique case (phase_reg)
            PH_IDLE:
                if (tick_word.check_request)
                begin
                    if (!cfg_word.pins_configured)
                        result_word.status = ST_NOT_CONF;
                    else if (tick_word.scl_level && tick_word.sda_level)
                        result_word.status = ST_OK;
                    else
                        result_word.status = ST_CLEARING;
                end
            PH_WAIT_SCL:
                result_word.status = (!tick_word.scl_level && expired) ? ST_SCL_STUCK
                                                                       : ST_CLEARING;
            PH_STRETCH:
                result_word.status = (!tick_word.scl_level && expired) ? ST_STRETCH
                                                                       : ST_CLEARING;
            PH_SDA_CHECK, PH_PULSE_CHECK:
                if (decide && !tick_word.sda_level && !have_pulse)
                    result_word.status = ST_SDA_STUCK;
                else
                    result_word.status = ST_CLEARING;
            PH_PULSE_RELEASE, PH_STOP_COND:
                result_word.status = ST_CLEARING;
            PH_FINISH:
                result_word.status = ST_CLEARED;
        endcase
        result_word.scl_drive_low = decide && !tick_word.sda_level && have_pulse;
        result_word.sda_drive_low = decide && tick_word.sda_level;
        result_word.pullup_enable = (result_word.status == ST_CLEARING);
    end

    always_comb
    begin
        wait_timer_next  = wait_timer_reg;
        pulses_left_next = pulses_left_reg;
        if (phase_reg == PH_IDLE && start_clear)
        begin
            wait_timer_next  = '0;
            pulses_left_next = cfg_word.max_pulses;
        end
        else if ((phase_reg == PH_WAIT_SCL || phase_reg == PH_STRETCH) &&
                 !tick_word.scl_level)
        begin
            wait_timer_next = timer_inc;
        end
        else if (phase_reg == PH_PULSE_CHECK && !tick_word.scl_level)
        begin
            wait_timer_next = '0;
        end
        else if (decide && !tick_word.sda_level && have_pulse)
        begin
            pulses_left_next = pulses_left_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg       <= PH_IDLE;
            wait_timer_reg  <= '0;
            pulses_left_reg <= '0;
        end
        else if (accept)
        begin
            phase_reg       <= phase_next;
            wait_timer_reg  <= wait_timer_next;
            pulses_left_reg <= pulses_left_next;
        end
    end

endmodule

// File: hdl/i2cbc_out_reg.sv
// result register that frees itself when the word is taken
`timescale 1ns / 1ps

module i2cbc_out_reg (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               load,
    input  i2cbc_pkg::result_t result_word,
    output logic               slot_free,
    i2cbc_stream_if.source     result
);
    import i2cbc_pkg::*;

    logic    valid_reg;
    logic    valid_next;
    result_t data_reg;

    // accept a new word when empty or when the held one leaves this cycle
    assign slot_free = !valid_reg || result.ready;

    always_comb
    begin
        valid_next = valid_reg;
        if (load)
            valid_next = 1'b1;
        else if (result.ready)
            valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (load)
            data_reg <= result_word;
    end

    assign result.valid   = valid_reg;
    assign result.payload = data_reg;

endmodule

// File: hdl/i2c_bus_clear_sequencer_unit.sv
// i2c bus clear sequencer: one result word per accepted tick word
// result word is registered and valid in the cycle after its tick word is accepted
// throughput: one tick word per cycle unless a held result word waits on result.ready,
//   set by the single state update per tick and the one-entry result register
// reset: phase idle, wait timer and pulse budget zero, config registers at defaults
`timescale 1ns / 1ps
`include "assert_macros.svh"

module i2c_bus_clear_sequencer_unit #(
    parameter int TIMER_BITS = 24
) (
    input  logic           clk,
    input  logic           rst_n,
    i2cbc_cfg_if.sink      cfg,
    i2cbc_stream_if.sink   tick,
    i2cbc_stream_if.source result
);
    import i2cbc_pkg::*;

    cfg_t    cfg_word;
    tick_t   tick_word;
    result_t result_word;
    logic    slot_free;
    logic    tick_accept;

    assign tick_word   = tick.payload;
    assign tick.ready  = slot_free;
    assign tick_accept = tick.valid && slot_free;

    i2cbc_cfg_regs u_cfg_regs (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg),
        .cfg_word (cfg_word)
    );

    i2cbc_seq_core #(
        .TIMER_BITS (TIMER_BITS)
    ) u_seq_core (
        .clk         (clk),
        .rst_n       (rst_n),
        .accept      (tick_accept),
        .tick_word   (tick_word),
        .cfg_word    (cfg_word),
        .result_word (result_word)
    );

    i2cbc_out_reg u_out_reg (
        .clk         (clk),
        .rst_n       (rst_n),
        .load        (tick_accept),
        .result_word (result_word),
        .slot_free   (slot_free),
        .result      (result)
    );

    // a held word must block new ticks
    `I2CBC_ASSERT_SAME(a_no_overwrite, result.valid && !result.ready, !tick.ready, "tick taken while result word held")
    // an accepted tick always leaves a word behind
    `I2CBC_ASSERT_NEXT(a_word_follows, tick_accept, result.valid, "accepted tick gave no result word")
    // pull-ups only while clearing
    `I2CBC_ASSERT_SAME(a_pullup_clearing, tick_accept, result_word.pullup_enable == (result_word.status == ST_CLEARING), "pull-up enable does not match clearing status")
    // never drive both lines low together
    `I2CBC_ASSERT_SAME(a_single_drive, tick_accept, !(result_word.scl_drive_low && result_word.sda_drive_low), "both lines driven low")

endmodule
